// ===== design/hvsu_pkg.sv =====
// Package: shared types and constants for the HMM Viterbi state update block
`timescale 1ns / 1ps
`default_nettype none
package hvsu_pkg;

  typedef enum logic [1:0] {
    MODE_CLEAR = 2'd0,
    MODE_ENTER = 2'd1,
    MODE_EVAL  = 2'd2,
    MODE_LOAD  = 2'd3
  } mode_t;

  localparam int unsigned NUM_ARCS     = 36;
  localparam int unsigned NUM_STATES   = 5;
  localparam logic [31:0] NO_HISTORY   = 32'hFFFF_FFFF;
  localparam logic [31:0] LOG_ZERO_RST = 32'hC800_0000;

  typedef enum logic [0:0] {
    CFG_TOPOLOGY = 1'b0,
    CFG_LOG_ZERO = 1'b1
  } cfg_idx_t;

  typedef logic signed [31:0] score_t;

  // wrapping add that saturates negative underflow to the most negative value, unless the wrapped sum is zero
  function automatic score_t sadd(input score_t a, input score_t b);
    score_t c;
    c = a + b;
    if (a[31] && b[31] && !c[31] && (c != '0)) c = 32'sh8000_0000;
    return c;
  endfunction

endpackage
`default_nettype wire

// ===== design/hmm_viterbi_state_update_top.sv =====
// Top level: slot table, matrix table and the max-plus frame update
// An evaluate result is offered from the output register after the read and write-back states.
// A new request is taken only in idle, so each one goes through read, compute and write back/emit,
//   the single read/modify/write pass through the slot memories, before the next is taken.
// Results sit in an output register; the next request may run while one waits;
//   an evaluate then holds in write back until the register frees.
// Reset clears the sequencer, out_valid and the configuration; memories hold garbage until written.
`timescale 1ns / 1ps
`default_nettype none
module hmm_viterbi_state_update_top #(
  parameter int NUM_HMM_SLOTS = 1024,
  parameter int NUM_MATRICES  = 64
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [1:0]  in_mode,
  input  wire logic [9:0]  in_hmm_slot,
  input  wire logic [5:0]  in_matrix_id,
  input  wire logic signed [31:0] in_senone_score_0,
  input  wire logic signed [31:0] in_senone_score_1,
  input  wire logic signed [31:0] in_senone_score_2,
  input  wire logic signed [31:0] in_senone_score_3,
  input  wire logic signed [31:0] in_senone_score_4,
  input  wire logic signed [31:0] in_entry_score,
  input  wire logic signed [31:0] in_entry_history,
  input  wire logic [5:0]  in_arc_index,
  input  wire logic signed [31:0] in_arc_weight,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic signed [31:0] out_best_score,
  output logic signed [31:0] out_exit_score,
  output logic signed [31:0] out_exit_history,
  input  wire logic        cfg_we,
  input  wire logic        cfg_index,
  input  wire logic [31:0] cfg_wdata
);
  import hvsu_pkg::*;

  localparam int SW = (NUM_HMM_SLOTS > 1) ? $clog2(NUM_HMM_SLOTS) : 1;
  localparam int MW = (NUM_MATRICES > 1) ? $clog2(NUM_MATRICES) : 1;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_READ = 3'b010,
    ST_WB   = 3'b100
  } fsm_t;

  // configuration
  logic   five_r;
  score_t lz_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      five_r <= 1'b0;
      lz_r   <= LOG_ZERO_RST;
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_TOPOLOGY: five_r <= cfg_wdata[0];
        CFG_LOG_ZERO: lz_r   <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // memories: one row per slot holds 5 scores and 5 histories; entry pair;
  // one row per matrix holds 36 weights
  logic [NUM_STATES*32-1:0] sc_mem [NUM_HMM_SLOTS];
  logic [NUM_STATES*32-1:0] hi_mem [NUM_HMM_SLOTS];
  logic [63:0]              en_mem [NUM_HMM_SLOTS];
  logic [NUM_ARCS*32-1:0]   tr_mem [NUM_MATRICES];

  fsm_t state_r, state_nxt;
  logic [1:0] mode_r;
  logic [SW-1:0] slot_r;
  logic [MW-1:0] mat_r;
  score_t sen_r [NUM_STATES];
  logic [NUM_STATES*32-1:0] sc_q, hi_q;
  logic [63:0] en_q;
  logic [NUM_ARCS*32-1:0] tr_q;

  logic take;
  logic [SW-1:0] slot_in;
  logic [MW-1:0] mat_in;
  assign slot_in = SW'(32'(in_hmm_slot) % NUM_HMM_SLOTS);
  assign mat_in  = MW'(32'(in_matrix_id) % NUM_MATRICES);

  // output register is free when empty or being drained
  logic out_free;
  assign out_free = !out_valid || !out_stall;
  assign in_stall = (state_r != ST_IDLE);
  assign take     = in_valid && !in_stall;

  // request capture
  always_ff @(posedge clk) begin
    if (take) begin
      mode_r <= in_mode;
      slot_r <= slot_in;
      mat_r  <= mat_in;
      sen_r[0] <= in_senone_score_0;
      sen_r[1] <= in_senone_score_1;
      sen_r[2] <= in_senone_score_2;
      sen_r[3] <= in_senone_score_3;
      sen_r[4] <= in_senone_score_4;
    end
  end

  // enter and load write on acceptance, evaluate and clear in ST_WB; rows read on acceptance
  always_ff @(posedge clk) begin
    if (take && mode_t'(in_mode) == MODE_ENTER)
      en_mem[slot_in] <= {in_entry_history, in_entry_score};
    else if (state_r == ST_WB && mode_t'(mode_r) == MODE_EVAL)
      en_mem[slot_r] <= {en_q[63:32], lz_r};
    else if (state_r == ST_WB && mode_t'(mode_r) == MODE_CLEAR)
      en_mem[slot_r] <= {NO_HISTORY, lz_r};
    if (take) en_q <= en_mem[slot_in];
  end

  always_ff @(posedge clk) begin
    if (take && mode_t'(in_mode) == MODE_LOAD && in_arc_index < 6'(NUM_ARCS))
      tr_mem[mat_in][in_arc_index*32 +: 32] <= in_arc_weight;
    if (take) tr_q <= tr_mem[mat_in];
  end

  // evaluate datapath on the read row
  score_t s [NUM_STATES];
  score_t h [NUM_STATES];
  score_t ns [NUM_STATES];
  score_t nh [NUM_STATES];
  score_t best, xs, xh;

  function automatic score_t tw(input logic [NUM_ARCS*32-1:0] t, input int idx);
    return t[idx*32 +: 32];
  endfunction

  always_comb begin
    score_t a0, a1, a2, a3, a4, p, in_s;
    for (int i = 0; i < NUM_STATES; i++) begin
      s[i]  = sc_q[i*32 +: 32];
      h[i]  = hi_q[i*32 +: 32];
      ns[i] = s[i];
      nh[i] = h[i];
    end
    in_s = en_q[31:0];
    a0 = '0; a1 = '0; a2 = '0; a3 = '0; a4 = '0; p = '0;
    best = '0; xs = '0; xh = '0;
    if (five_r) begin
      a4 = sadd(s[4], tw(tr_q, 28)); a3 = sadd(s[3], tw(tr_q, 22));
      a2 = sadd(s[2], tw(tr_q, 16));
      if (a4 < a3) begin
        if (a3 >= a2) begin p = a3; nh[4] = h[3]; end else begin p = a2; nh[4] = h[2]; end
      end else if (a4 < a2) begin p = a2; nh[4] = h[2]; end else p = a4;
      ns[4] = sadd(p, sen_r[4]);
      a3 = sadd(s[3], tw(tr_q, 21)); a2 = sadd(s[2], tw(tr_q, 15));
      a1 = sadd(s[1], tw(tr_q, 9));
      if (a3 < a2) begin
        if (a2 >= a1) begin p = a2; nh[3] = h[2]; end else begin p = a1; nh[3] = h[1]; end
      end else if (a3 < a1) begin p = a1; nh[3] = h[1]; end else p = a3;
      ns[3] = sadd(p, sen_r[3]);
      best = (ns[4] > ns[3]) ? ns[4] : ns[3];
      a4 = sadd(ns[4], tw(tr_q, 29)); a3 = sadd(ns[3], tw(tr_q, 23));
      if (a4 < a3) begin xs = a3; xh = nh[3]; end else begin xs = a4; xh = nh[4]; end
      a2 = sadd(s[2], tw(tr_q, 14)); a1 = sadd(s[1], tw(tr_q, 8));
      a0 = sadd(s[0], tw(tr_q, 2));
      if (a2 < a1) begin
        if (a1 >= a0) begin p = a1; nh[2] = h[1]; end else begin p = a0; nh[2] = h[0]; end
      end else if (a2 < a0) begin p = a0; nh[2] = h[0]; end else p = a2;
      ns[2] = sadd(p, sen_r[2]);
      if (best < ns[2]) best = ns[2];
      a1 = sadd(s[1], tw(tr_q, 7)); a0 = sadd(s[0], tw(tr_q, 1));
      if (a1 < a0) begin p = a0; nh[1] = h[0]; end else p = a1;
      ns[1] = sadd(p, sen_r[1]);
      if (best < ns[1]) best = ns[1];
    end else begin
      a2 = sadd(s[2], tw(tr_q, 10)); a1 = sadd(s[1], tw(tr_q, 6));
      a0 = sadd(s[0], tw(tr_q, 2));
      if (tw(tr_q, 2) > lz_r) begin
        if (a2 < a1) begin
          if (a1 >= a0) begin p = a1; nh[2] = h[1]; end else begin p = a0; nh[2] = h[0]; end
        end else if (a2 < a0) begin p = a0; nh[2] = h[0]; end else p = a2;
      end else begin
        if (a2 < a1) begin p = a1; nh[2] = h[1]; end else p = a2;
      end
      ns[2] = sadd(p, sen_r[2]);
      a1 = sadd(s[1], tw(tr_q, 5)); a0 = sadd(s[0], tw(tr_q, 1));
      if (a1 < a0) begin p = a0; nh[1] = h[0]; end else p = a1;
      ns[1] = sadd(p, sen_r[1]);
      best = (ns[2] > ns[1]) ? ns[2] : ns[1];
      a2 = sadd(ns[2], tw(tr_q, 11));
      xs = a2; xh = nh[2];
      if (tw(tr_q, 7) > lz_r) begin
        a1 = sadd(ns[1], tw(tr_q, 7));
        if (a2 < a1) begin xs = a1; xh = nh[1]; end
      end
    end
    a0 = sadd(s[0], tw(tr_q, 0));
    if (a0 < in_s) begin p = in_s; nh[0] = en_q[63:32]; end else p = a0;
    ns[0] = sadd(p, sen_r[0]);
    if (best < ns[0]) best = ns[0];
  end

  // slot memories: read on acceptance, write back in ST_WB on clear and evaluate
  logic [NUM_STATES*32-1:0] sc_wr, hi_wr;
  always_comb begin
    for (int i = 0; i < NUM_STATES; i++) begin
      sc_wr[i*32 +: 32] = (mode_t'(mode_r) == MODE_CLEAR) ? lz_r : ns[i];
      hi_wr[i*32 +: 32] = (mode_t'(mode_r) == MODE_CLEAR) ? NO_HISTORY : nh[i];
    end
  end

  logic wb_en;
  assign wb_en = (state_r == ST_WB) &&
                 (mode_t'(mode_r) == MODE_CLEAR || mode_t'(mode_r) == MODE_EVAL);

  always_ff @(posedge clk) begin
    if (wb_en) begin
      sc_mem[slot_r] <= sc_wr;
      hi_mem[slot_r] <= hi_wr;
    end
    if (take) begin
      sc_q <= sc_mem[slot_in];
      hi_q <= hi_mem[slot_in];
    end
  end

  // sequencer: idle -> read -> write back (waits for output register on evaluate)
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: if (take) state_nxt = ST_READ;
      ST_READ: state_nxt = ST_WB;
      ST_WB:   if (mode_t'(mode_r) != MODE_EVAL || out_free) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  logic emit;
  assign emit = (state_r == ST_WB) && (mode_t'(mode_r) == MODE_EVAL) && out_free;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (emit) out_valid <= 1'b1;
      else if (!out_stall) out_valid <= 1'b0;
    end
  end

  // hold-in-place write back: WB stalls until output frees, memory write repeats harmlessly
  always_ff @(posedge clk) begin
    if (emit) begin
      out_best_score   <= best;
      out_exit_score   <= xs;
      out_exit_history <= xh;
    end
  end

`ifndef ASSERT_OFF
  a_onehot: assert property (@(posedge clk) disable iff (!rst_n) $onehot(state_r))
    else $error("sequencer state not one-hot");
  a_no_take_busy: assert property (@(posedge clk) disable iff (!rst_n)
    state_r != ST_IDLE |-> !take) else $error("request taken while busy");
  a_read_wb: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_READ |=> state_r == ST_WB) else $error("read not followed by write back");
  a_emit_eval: assert property (@(posedge clk) disable iff (!rst_n)
    emit |-> mode_t'(mode_r) == MODE_EVAL) else $error("result from non-evaluate");
`endif

endmodule
`default_nettype wire

// ===== sim/hmm_viterbi_state_update_top_tb.sv =====
// Testbench: random and directed checking of the HMM Viterbi state update block
`timescale 1ns / 1ps
`default_nettype none
module hmm_viterbi_state_update_top_tb;
  import hvsu_pkg::*;

  // Frame predictor plus the queue of expected frame results
  class viterbi_scoreboard;
    score_t state_sc[5120];
    score_t state_hist[5120];
    score_t entry_sc[1024];
    score_t entry_hist[1024];
    score_t arc_w[2304];
    bit     five_state;
    score_t log_zero;
    score_t want_best[$];
    score_t want_exit[$];
    score_t want_hist[$];
    int     errors;
    int     frames_checked;

    function new();
      five_state = 1'b0;
      log_zero = LOG_ZERO_RST;
      errors = 0;
      frames_checked = 0;
    endfunction

    function score_t add(score_t a, score_t b);
      score_t c;
      c = a + b;
      if (c > 0 && a < 0 && b < 0) c = 32'sh8000_0000;
      return c;
    endfunction

    // self, nearer, farther; ties as the C comparison order resolves them
    function score_t best_of3(score_t x, score_t y, score_t z, inout score_t h,
                              input score_t hy, input score_t hz);
      if (x < y) begin
        if (y >= z) begin
          h = hy;
          return y;
        end
        h = hz;
        return z;
      end
      if (x < z) begin
        h = hz;
        return z;
      end
      return x;
    endfunction

    function score_t best_of2(score_t x, score_t y, inout score_t h, input score_t hy);
      if (x < y) begin
        h = hy;
        return y;
      end
      return x;
    endfunction

    task report(string what, score_t got, score_t want);
      errors++;
      $display("mismatch %s: got %0d expected %0d", what, got, want);
    endtask

    // note an accepted request; evaluate requests queue one expected result
    function void note_request(mode_t mode, int slot, int mat, score_t sen[5],
                               score_t esc, score_t ehist, int arc, score_t wgt);
      int b, t;
      score_t a0, a1, a2, a3, a4, best, xs, xh, h0, h1, h2, h3, h4;
      b = slot * 5;
      t = mat * 36;
      case (mode)
        MODE_CLEAR: begin
          for (int i = 0; i < 5; i++) begin
            state_sc[b + i] = log_zero;
            state_hist[b + i] = NO_HISTORY;
          end
          entry_sc[slot] = log_zero;
          entry_hist[slot] = NO_HISTORY;
        end
        MODE_ENTER: begin
          entry_sc[slot] = esc;
          entry_hist[slot] = ehist;
        end
        MODE_LOAD: begin
          if (arc < 36) arc_w[t + arc] = wgt;
        end
        default: begin
          h0 = state_hist[b];
          h1 = state_hist[b + 1];
          h2 = state_hist[b + 2];
          h3 = state_hist[b + 3];
          h4 = state_hist[b + 4];
          if (five_state) begin
            a4 = add(state_sc[b + 4], arc_w[t + 28]);
            a3 = add(state_sc[b + 3], arc_w[t + 22]);
            a2 = add(state_sc[b + 2], arc_w[t + 16]);
            a4 = add(best_of3(a4, a3, a2, h4, h3, h2), sen[4]);
            a3 = add(state_sc[b + 3], arc_w[t + 21]);
            a2 = add(state_sc[b + 2], arc_w[t + 15]);
            a1 = add(state_sc[b + 1], arc_w[t + 9]);
            a3 = add(best_of3(a3, a2, a1, h3, h2, h1), sen[3]);
            best = (a4 > a3) ? a4 : a3;
            if (add(a4, arc_w[t + 29]) < add(a3, arc_w[t + 23])) begin
              xs = add(a3, arc_w[t + 23]);
              xh = h3;
            end else begin
              xs = add(a4, arc_w[t + 29]);
              xh = h4;
            end
            a2 = add(state_sc[b + 2], arc_w[t + 14]);
            a1 = add(state_sc[b + 1], arc_w[t + 8]);
            a0 = add(state_sc[b], arc_w[t + 2]);
            a2 = add(best_of3(a2, a1, a0, h2, h1, h0), sen[2]);
            if (best < a2) best = a2;
            a1 = add(state_sc[b + 1], arc_w[t + 7]);
            a0 = add(state_sc[b], arc_w[t + 1]);
            a1 = add(best_of2(a1, a0, h1, h0), sen[1]);
            if (best < a1) best = a1;
            state_sc[b + 4] = a4;
            state_sc[b + 3] = a3;
          end else begin
            a2 = add(state_sc[b + 2], arc_w[t + 10]);
            a1 = add(state_sc[b + 1], arc_w[t + 6]);
            // skip arc only counts above log zero
            if (arc_w[t + 2] > log_zero) begin
              a0 = add(state_sc[b], arc_w[t + 2]);
              a2 = best_of3(a2, a1, a0, h2, h1, h0);
            end else begin
              a2 = best_of2(a2, a1, h2, h1);
            end
            a2 = add(a2, sen[2]);
            a1 = add(state_sc[b + 1], arc_w[t + 5]);
            a0 = add(state_sc[b], arc_w[t + 1]);
            a1 = add(best_of2(a1, a0, h1, h0), sen[1]);
            best = (a2 > a1) ? a2 : a1;
            xs = add(a2, arc_w[t + 11]);
            xh = h2;
            if (arc_w[t + 7] > log_zero) begin
              if (xs < add(a1, arc_w[t + 7])) begin
                xs = add(a1, arc_w[t + 7]);
                xh = h1;
              end
            end
          end
          a0 = add(state_sc[b], arc_w[t]);
          a0 = add(best_of2(a0, entry_sc[slot], h0, entry_hist[slot]), sen[0]);
          if (best < a0) best = a0;
          state_sc[b] = a0;
          state_sc[b + 1] = a1;
          state_sc[b + 2] = a2;
          state_hist[b] = h0;
          state_hist[b + 1] = h1;
          state_hist[b + 2] = h2;
          state_hist[b + 3] = h3;
          state_hist[b + 4] = h4;
          entry_sc[slot] = log_zero;
          want_best.push_back(best);
          want_exit.push_back(xs);
          want_hist.push_back(xh);
        end
      endcase
    endfunction

    task check_result(score_t best, score_t xs, score_t xh);
      if (want_best.size() == 0) begin
        errors++;
        $display("mismatch: result with nothing expected");
      end else begin
        frames_checked++;
        if (best !== want_best[0]) report("best_score", best, want_best[0]);
        if (xs !== want_exit[0]) report("exit_score", xs, want_exit[0]);
        if (xh !== want_hist[0]) report("exit_history", xh, want_hist[0]);
        void'(want_best.pop_front());
        void'(want_exit.pop_front());
        void'(want_hist.pop_front());
      end
    endtask
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [1:0] in_mode = MODE_CLEAR;
  logic [9:0] in_hmm_slot = '0;
  logic [5:0] in_matrix_id = '0;
  score_t in_senone_score_0 = '0;
  score_t in_senone_score_1 = '0;
  score_t in_senone_score_2 = '0;
  score_t in_senone_score_3 = '0;
  score_t in_senone_score_4 = '0;
  score_t in_entry_score = '0;
  score_t in_entry_history = '0;
  logic [5:0] in_arc_index = '0;
  score_t in_arc_weight = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  score_t out_best_score, out_exit_score, out_exit_history;
  logic cfg_we = 1'b0;
  logic cfg_index = CFG_TOPOLOGY;
  logic [31:0] cfg_wdata = '0;

  viterbi_scoreboard sb = new();
  bit  quiet = 1'b0;
  bit  slot_live[1024];
  int  live_slots[$];
  int  ready_mats[$];
  int  requests = 0;
  int  out_hold = 0;

  hmm_viterbi_state_update_top DUT (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // result side: random stall bursts and checking
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && !out_stall)
        sb.check_result(out_best_score, out_exit_score, out_exit_history);
      if (out_hold > 0) begin
        out_hold <= out_hold - 1;
        out_stall <= 1'b1;
      end else if (!quiet && $urandom_range(0, 5) == 0) begin
        out_hold <= $urandom_range(0, 3);
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  function automatic score_t rand_score();
    case ($urandom_range(0, 7))
      0: return 32'sh8000_0000;
      1: return 32'sh7FFF_FFFF;
      2: return $urandom();
      3: return 0;
      default: return -$signed({1'b0, 31'($urandom_range(0, 200000))});
    endcase
  endfunction

  function automatic score_t rand_weight();
    case ($urandom_range(0, 7))
      0: return 32'sh8000_0000;
      1: return 0;
      2: return sb.log_zero;
      3: return (sb.log_zero == 0) ? 0 : sb.log_zero + 1;
      4: return {1'b1, 31'($urandom())};
      default: return -$signed({1'b0, 31'($urandom_range(0, 5000))});
    endcase
  endfunction

  // one request; waits for acceptance and may then idle
  task automatic send(mode_t mode, int slot, int mat, int arc, score_t wgt,
                      score_t esc, score_t ehist);
    score_t sen[5];
    for (int i = 0; i < 5; i++) sen[i] = rand_score();
    in_valid <= 1'b1;
    in_mode <= mode;
    in_hmm_slot <= 10'(slot);
    in_matrix_id <= 6'(mat);
    in_senone_score_0 <= sen[0];
    in_senone_score_1 <= sen[1];
    in_senone_score_2 <= sen[2];
    in_senone_score_3 <= sen[3];
    in_senone_score_4 <= sen[4];
    in_entry_score <= esc;
    in_entry_history <= ehist;
    in_arc_index <= 6'(arc);
    in_arc_weight <= wgt;
    do @(posedge clk); while (in_stall);
    sb.note_request(mode, slot, mat, sen, esc, ehist, arc, wgt);
    requests++;
    if (mode == MODE_CLEAR && !slot_live[slot]) begin
      slot_live[slot] = 1'b1;
      live_slots.push_back(slot);
    end
    if (!quiet && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
  endtask

  task automatic load_matrix(int mat);
    for (int a = 0; a < 36; a++) send(MODE_LOAD, mat, mat, a, rand_weight(), 0, 0);
    ready_mats.push_back(mat);
  endtask

  // sender holds off until every expected result is back and the pipe is empty
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.want_best.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_reg(cfg_idx_t idx, logic [31:0] val);
    drain();
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == CFG_TOPOLOGY) sb.five_state = val[0];
    else sb.log_zero = val;
  endtask

  task automatic random_request();
    int slot, mat;
    slot = live_slots[$urandom_range(0, live_slots.size() - 1)];
    mat = ready_mats[$urandom_range(0, ready_mats.size() - 1)];
    case ($urandom_range(0, 9))
      0: send(MODE_CLEAR, $urandom_range(0, 1023), 0, 0, 0, 0, 0);
      1, 2: send(MODE_ENTER, slot, $urandom(), $urandom(), 0, rand_score(),
                 ($urandom_range(0, 3) == 0) ? NO_HISTORY : {1'b0, 31'($urandom())});
      3: send(MODE_LOAD, $urandom(), mat, $urandom_range(0, 63), rand_weight(), 0, 0);
      4: send(MODE_LOAD, 0, mat, $urandom_range(0, 35), rand_weight(), 0, 0);
      default: send(MODE_EVAL, slot, mat, $urandom(), $urandom(), $urandom(), $urandom());
    endcase
  endtask

  initial begin
    #2_000_000;
    $display("FAIL hmm_viterbi_state_update_top");
    $finish;
  end

  initial begin
    logic [31:0] lz_set[5];
    lz_set = '{32'h8000_0000, 32'h0000_0000, 32'hC800_0000, 32'hFFFF_FFFF, 32'h8000_0001};
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: extreme slots, matrices 0 and 63 plus a random one, entries and frames with edge scores
    send(MODE_CLEAR, 0, 0, 0, 0, 0, 0);
    send(MODE_CLEAR, 1023, 0, 0, 0, 0, 0);
    load_matrix(0);
    load_matrix(63);
    send(MODE_LOAD, 0, 63, 63, 32'sh8000_0000, 0, 0);
    send(MODE_ENTER, 0, 0, 0, 0, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF);
    send(MODE_EVAL, 0, 0, 0, 0, 0, 0);
    send(MODE_ENTER, 1023, 0, 0, 0, 32'sh8000_0000, NO_HISTORY);
    send(MODE_EVAL, 1023, 63, 0, 0, 0, 0);
    send(MODE_EVAL, 0, 63, 0, 0, 0, 0);
    for (int i = 0; i < 6; i++) send(MODE_CLEAR, $urandom_range(1, 1022), 0, 0, 0, 0, 0);
    load_matrix($urandom_range(1, 62));
    write_reg(CFG_TOPOLOGY, 1);
    send(MODE_ENTER, 0, 0, 0, 0, 0, 5);
    send(MODE_EVAL, 0, 0, 0, 0, 0, 0);
    send(MODE_EVAL, 1023, 63, 0, 0, 0, 0);

    // random phases across topology and log-zero settings
    for (int ph = 0; ph < 5; ph++) begin
      write_reg(CFG_TOPOLOGY, ph % 2);
      write_reg(CFG_LOG_ZERO, (ph == 4) ? {1'b1, 31'($urandom())} : lz_set[ph]);
      quiet = (ph == 4);
      for (int n = 0; n < 55; n++) begin
        if (n == 35 && ph == 1) drain();
        random_request();
      end
    end

    drain();
    if (sb.want_best.size() != 0) sb.errors++;
    $display("covered %0d requests, %0d frame results checked, both topologies,",
             requests, sb.frames_checked);
    $display("log zero at both extremes and random, with stalls on both sides");
    if (sb.errors == 0) begin
      $display("PASS hmm_viterbi_state_update_top");
    end else begin
      $display("FAIL hmm_viterbi_state_update_top");
    end
    $finish;
  end
endmodule
`default_nettype wire

// ===== hmm_viterbi_state_update_top.f =====
design/hvsu_pkg.sv
design/hmm_viterbi_state_update_top.sv
sim/hmm_viterbi_state_update_top_tb.sv
